@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/eagu_pkg.sv @@
// Package of the elite archive grid: sizes, payload structs, codes and the
// bin count function. No dependencies.
`timescale 1ns / 1ps

package eagu_pkg;

  localparam int BINS     = 4;
  localparam int DIMS     = 2;
  localparam int CELLS    = BINS * BINS;
  localparam int LIM_W    = 16;
  localparam int SCORE_W  = 32;
  localparam int ID_W     = 16;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int BIN_W    = $clog2(BINS);
  localparam int CNT_W    = $clog2(BINS + 1);
  localparam int CFG_W    = $clog2(DIMS * BINS);
  localparam int LIM_STEP = 256;

  typedef logic signed [LIM_W-1:0]   q88_t;
  typedef logic signed [SCORE_W-1:0] q1616_t;
  typedef q88_t [BINS-1:0]           lim_row_t;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_QUERY = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    ALU_BIN = 1'b0,
    ALU_DIV = 1'b1
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t mode;
    logic      last;
  } alu_ctl_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    q1616_t           score;
    logic [ID_W-1:0]  id;
  } store_wr_t;

  typedef struct packed {
    logic [1:0]       op;
    q88_t             coord_a;
    q88_t             coord_b;
    q1616_t           score;
    logic [ID_W-1:0]  candidate_id;
    logic [IDX_W-1:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_res;
    logic             out_of_range;
    logic             visited;
    q1616_t           stored_score;
    logic [ID_W-1:0]  stored_id;
    logic             replaced;
    q88_t             cell_coord_a;
    q88_t             cell_coord_b;
  } out_t;

  // Bins in use: length of the non-decreasing prefix of the limits.
  function automatic logic [CNT_W-1:0] bin_count(lim_row_t l);
    logic [CNT_W-1:0] n;
    n = CNT_W'(BINS);
    for (int j = BINS - 1; j >= 1; j--) begin
      if (l[j] < l[j-1]) n = CNT_W'(j);
    end
    return n;
  endfunction

endpackage

@@ sv/elite_archive_grid_update.sv @@
// Elite archive over a 4x4 behavior grid; top level. Uses eagu_pkg, eagu_alu,
// eagu_store and assert_macros.svh.
// Offers and queries step the compare unit once per bin tested (up to 8); reads
// step it once per divide step. One item at a time, and a result that waits
// holds off the next item.
// Reset (synchronous, rst high) restores limits to j*256 and clears all cells.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module elite_archive_grid_update (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  eagu_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output eagu_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [eagu_pkg::CFG_W-1:0]    cfg_index,
  input  logic [eagu_pkg::LIM_W-1:0]    cfg_data
);
  import eagu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BIN  = 5'b00010,
    S_DIV  = 5'b00100,
    S_RD   = 5'b01000,
    S_CMP  = 5'b10000
  } state_t;

  state_t state, state_next;

  lim_row_t lim_a, lim_b;
  logic [CNT_W-1:0] nb_a, nb_b, n_cur;
  logic [2*CNT_W-1:0] total;

  in_t              item;
  logic             dim;
  logic [BIN_W-1:0] j;
  logic [BIN_W-1:0] bin_a, bin_b;
  logic [IDX_W-1:0] rem;
  logic [IDX_W-1:0] cell_idx;
  logic             bad;

  alu_ctl_t         alu_ctl;
  q88_t             alu_coord;
  lim_row_t         row;
  logic             alu_le;
  logic [IDX_W-1:0] alu_diff;
  logic [IDX_W+CNT_W-1:0] cell_calc;

  store_wr_t        wr;
  logic             rd_vis;
  q1616_t           rd_score;
  logic [ID_W-1:0]  rd_id;

  logic             out_free;
  logic             replace;
  out_t             res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BINS; k++) begin
        lim_a[k] <= LIM_W'(k * LIM_STEP);
        lim_b[k] <= LIM_W'(k * LIM_STEP);
      end
    end else if (cfg_we) begin
      if (cfg_index[CFG_W-1]) lim_b[cfg_index[BIN_W-1:0]] <= cfg_data;
      else                    lim_a[cfg_index[BIN_W-1:0]] <= cfg_data;
    end
  end

  assign nb_a  = bin_count(lim_a);
  assign nb_b  = bin_count(lim_b);
  assign total = (2*CNT_W)'(nb_a) * (2*CNT_W)'(nb_b);

  // Compare unit operands
  assign row       = dim ? lim_b : lim_a;
  assign n_cur     = dim ? nb_b : nb_a;
  assign alu_coord = dim ? item.coord_b : item.coord_a;
  assign alu_ctl.mode = (state == S_DIV) ? ALU_DIV : ALU_BIN;
  assign alu_ctl.last = ({1'b0, j} + CNT_W'(1)) == n_cur;

  eagu_alu u_alu (
    .ctl     (alu_ctl),
    .coord   (alu_coord),
    .l_lo    (row[j]),
    .l_hi    (row[j + BIN_W'(1)]),
    .rem     (rem),
    .divisor (nb_b),
    .le      (alu_le),
    .diff    (alu_diff)
  );

  assign cell_calc = (IDX_W+CNT_W)'(bin_a) * (IDX_W+CNT_W)'(nb_b) + (IDX_W+CNT_W)'(j);

  eagu_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (cell_idx),
    .rd_vis   (rd_vis),
    .rd_score (rd_score),
    .rd_id    (rd_id)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign replace  = !bad && (op_t'(item.op) == OP_OFFER) &&
                    (!rd_vis || (item.score > rd_score));

  assign wr.en    = (state == S_CMP) && out_free && replace;
  assign wr.addr  = cell_idx;
  assign wr.score = item.score;
  assign wr.id    = item.candidate_id;

  always_comb begin
    res = '0;
    if (bad) begin
      res.out_of_range = 1'b1;
    end else begin
      res.cell_res     = cell_idx;
      res.visited      = rd_vis || replace;
      res.stored_score = replace ? item.score : rd_score;
      res.stored_id    = replace ? item.candidate_id : rd_id;
      res.replaced     = replace;
      res.cell_coord_a = lim_a[bin_a];
      res.cell_coord_b = lim_b[bin_b];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_data.op) == OP_NONE) state_next = S_RD;
          else if (op_t'(in_data.op) == OP_READ) begin
            if ((2*CNT_W)'(in_data.cell_index) >= total) state_next = S_RD;
            else                                         state_next = S_DIV;
          end else state_next = S_BIN;
        end
      end
      S_BIN:  if ((alu_le && dim) || (!alu_le && alu_ctl.last)) state_next = S_RD;
      S_DIV:  if (!alu_le) state_next = S_RD;
      S_RD:   state_next = S_CMP;
      S_CMP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bad       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CMP && out_free) out_valid <= 1'b1;
      else if (out_ready)             out_valid <= 1'b0;
      if (state == S_IDLE && in_valid) begin
        bad <= (op_t'(in_data.op) == OP_NONE) ||
               ((op_t'(in_data.op) == OP_READ) &&
                ((2*CNT_W)'(in_data.cell_index) >= total));
      end else if (state == S_BIN && !alu_le && alu_ctl.last) begin
        bad <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item     <= in_data;
        dim      <= 1'b0;
        j        <= '0;
        bin_a    <= '0;
        bin_b    <= '0;
        rem      <= in_data.cell_index;
        cell_idx <= '0;
      end
      S_BIN: begin
        if (alu_le) begin
          if (!dim) begin
            bin_a <= j;
            dim   <= 1'b1;
            j     <= '0;
          end else begin
            bin_b    <= j;
            cell_idx <= cell_calc[IDX_W-1:0];
          end
        end else begin
          j <= j + BIN_W'(1);
        end
      end
      S_DIV: begin
        if (alu_le) begin
          rem   <= alu_diff;
          bin_a <= bin_a + BIN_W'(1);
        end else begin
          bin_b    <= rem[BIN_W-1:0];
          cell_idx <= item.cell_index;
        end
      end
      S_CMP: if (out_free) out_data <= res;
      default: ;
    endcase
  end

  `AST_IMPL(a_oor_clean, out_valid && out_data.out_of_range, !out_data.replaced && !out_data.visited, "out-of-range result carries cell data")
  `AST_IMPL(a_repl_visited, out_valid && out_data.replaced, out_data.visited && !out_data.out_of_range, "replaced cell not marked visited")
  `AST_NEXT(a_result_load, state == S_CMP && out_free, state == S_IDLE && out_valid, "result not loaded after cell access")
  `AST_IMPL(a_write_offer, wr.en, op_t'(item.op) == OP_OFFER && !bad, "store written by non-offer or bad item")

endmodule

@@ sv/eagu_alu.sv @@
// Shared compare unit of the elite archive grid: bin threshold test and
// restoring divide step. Depends on eagu_pkg.
`timescale 1ns / 1ps

module eagu_alu (
  input  eagu_pkg::alu_ctl_t             ctl,
  input  eagu_pkg::q88_t                 coord,
  input  eagu_pkg::q88_t                 l_lo,
  input  eagu_pkg::q88_t                 l_hi,
  input  logic [eagu_pkg::IDX_W-1:0]     rem,
  input  logic [eagu_pkg::CNT_W-1:0]     divisor,
  output logic                           le,
  output logic [eagu_pkg::IDX_W-1:0]     diff
);
  import eagu_pkg::*;

  localparam int CW = LIM_W + 2;

  logic signed [CW-1:0] lhs;
  logic signed [CW-1:0] rhs;
  logic signed [CW-1:0] lo_x;
  logic signed [CW-1:0] hi_x;

  assign lo_x = CW'(l_lo);
  assign hi_x = CW'(l_hi);

  // Threshold: 2*c <= l[j] + l[j+1], last bin: 2*c <= 2*l[j] + 2.
  always_comb begin
    case (ctl.mode)
      ALU_BIN: begin
        lhs = {coord[LIM_W-1], coord, 1'b0};
        rhs = ctl.last ? (lo_x + lo_x + CW'(2)) : (lo_x + hi_x);
      end
      ALU_DIV: begin
        lhs = CW'({1'b0, divisor});
        rhs = CW'({1'b0, rem});
      end
      default: begin
        lhs = '0;
        rhs = '0;
      end
    endcase
  end

  assign le   = (lhs <= rhs);
  assign diff = rem - IDX_W'(divisor);

endmodule

@@ sv/eagu_store.sv @@
// Cell store of the elite archive grid: visited flags in flops, score and
// elite handle in a memory with registered read. Depends on eagu_pkg.
`timescale 1ns / 1ps

module eagu_store (
  input  logic                          clk,
  input  logic                          rst,
  input  eagu_pkg::store_wr_t           wr,
  input  logic [eagu_pkg::IDX_W-1:0]    rd_addr,
  output logic                          rd_vis,
  output eagu_pkg::q1616_t              rd_score,
  output logic [eagu_pkg::ID_W-1:0]     rd_id
);
  import eagu_pkg::*;

  logic [CELLS-1:0]          vis;
  logic [SCORE_W+ID_W-1:0]   mem [CELLS];
  logic [SCORE_W+ID_W-1:0]   rd_q;
  logic                      vis_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vis   <= '0;
      vis_q <= 1'b0;
    end else begin
      if (wr.en) vis[wr.addr] <= 1'b1;
      vis_q <= vis[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= {wr.score, wr.id};
    rd_q <= mem[rd_addr];
  end

  // Unvisited cells read as zero.
  assign rd_vis   = vis_q;
  assign rd_score = vis_q ? q1616_t'(rd_q[SCORE_W+ID_W-1:ID_W]) : '0;
  assign rd_id    = vis_q ? rd_q[ID_W-1:0] : '0;

endmodule
